### hdl/assert_macros.svh
// Assertion helpers used by the parser core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk outside reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check an implication on every rising edge of clk outside reset.
`define ASSERT_IMP(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

`endif

### hdl/uac_cdp_pkg.sv
package uac_cdp_pkg;

	// Table sizes
	localparam int MAX_TERMINALS     = 8;
	localparam int MAX_FEATURE_UNITS = 8;
	localparam int MAX_CLOCK_SOURCES = 4;

	localparam int TERM_CNT_W  = $clog2(MAX_TERMINALS + 1);
	localparam int FEAT_CNT_W  = $clog2(MAX_FEATURE_UNITS + 1);
	localparam int CLOCK_CNT_W = $clog2(MAX_CLOCK_SOURCES + 1);

	// Descriptor bytes kept per descriptor (byte 0 is the length, held apart)
	localparam int CAP_LAST = 12;

	// Descriptor codes
	localparam logic [7:0] CS_IFACE   = 8'h24;
	localparam logic [7:0] ST_HEADER  = 8'h01;
	localparam logic [7:0] ST_INPUT   = 8'h02;
	localparam logic [7:0] ST_OUTPUT  = 8'h03;
	localparam logic [7:0] ST_FEATURE = 8'h06;
	localparam logic [7:0] ST_CLOCK   = 8'h0A;

	localparam logic [7:0]  MIN_DESC_LEN = 8'h03;
	localparam logic [15:0] BCD_UAC2     = 16'h0200;
	localparam logic [7:0]  MUTE_MASK    = 8'h03;
	localparam logic [7:0]  VOLUME_MASK  = 8'h0C;
	localparam logic [7:0]  BYTE_MASK    = 8'hFF;

	// Class version codes
	localparam logic [1:0] VER_UNKNOWN = 2'd0;
	localparam logic [1:0] VER_1       = 2'd1;
	localparam logic [1:0] VER_2       = 2'd2;

	// Record kinds
	localparam logic [2:0] KIND_HEADER  = 3'd0;
	localparam logic [2:0] KIND_INPUT   = 3'd1;
	localparam logic [2:0] KIND_OUTPUT  = 3'd2;
	localparam logic [2:0] KIND_FEATURE = 3'd3;
	localparam logic [2:0] KIND_CLOCK   = 3'd4;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} item_t;

	typedef struct packed {
		logic [2:0]  record_kind;
		logic [2:0]  table_slot;
		logic [7:0]  entity_id;
		logic [15:0] type_word;
		logic [7:0]  assoc_terminal;
		logic [7:0]  source_id;
		logic [7:0]  channel_count;
		logic [15:0] channel_config;
		logic [7:0]  clock_source_id;
		logic [7:0]  clock_attributes;
		logic [7:0]  control_bits;
		logic [1:0]  feature_flags;
	} record_t;

	typedef logic [CAP_LAST:1][7:0] desc_bytes_t;

	// Walker to decoder: a descriptor completes this cycle
	typedef struct packed {
		logic        done;
		logic [7:0]  len;
		desc_bytes_t bytes;
	} walk_t;

endpackage

### hdl/uac_cdp_walker.sv
module uac_cdp_walker import uac_cdp_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  step,
	input  item_t item,
	output walk_t walk
);

	logic [7:0]  pos_q;
	logic [7:0]  len_q;
	logic        stopped_q;
	logic [7:0]  cap_q [1:CAP_LAST];
	logic [8:0]  pos_next;
	logic        body_byte;
	logic        done;
	desc_bytes_t view;

	// Advance position; a descriptor completes when it reaches the length
	assign pos_next  = {1'b0, pos_q} + 9'd1;
	assign body_byte = step && !stopped_q && (pos_q != 8'd0);
	assign done      = body_byte && (pos_next >= {1'b0, len_q});

	// Present the captured bytes with the current byte merged in
	always_comb begin
		for (int i = 1; i <= CAP_LAST; i++) begin
			view[i] = (pos_q == 8'(i)) ? item.data_byte : cap_q[i];
		end
	end

	assign walk.done  = done;
	assign walk.len   = len_q;
	assign walk.bytes = view;

	// Walk state: length byte, body bytes, stop and re-arm on the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= 8'd0;
			len_q     <= 8'd0;
			stopped_q <= 1'b0;
		end else if (step) begin
			if (item.last_byte) begin
				pos_q     <= 8'd0;
				stopped_q <= 1'b0;
			end else if (!stopped_q) begin
				if (pos_q == 8'd0) begin
					if (item.data_byte < MIN_DESC_LEN) begin
						stopped_q <= 1'b1;
					end else begin
						len_q <= item.data_byte;
						pos_q <= 8'd1;
					end
				end else begin
					pos_q <= done ? 8'd0 : pos_next[7:0];
				end
			end
		end
	end

	// Capture the leading body bytes
	always_ff @(posedge clk) begin
		if (body_byte && (pos_q <= 8'(CAP_LAST))) begin
			cap_q[pos_q[3:0]] <= item.data_byte;
		end
	end

endmodule

### hdl/uac_cdp_decoder.sv
module uac_cdp_decoder import uac_cdp_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  walk_t   walk,
	output logic    rec_valid,
	output record_t rec
);

	logic [1:0]             version_q;
	logic [TERM_CNT_W-1:0]  in_cnt_q;
	logic [TERM_CNT_W-1:0]  out_cnt_q;
	logic [FEAT_CNT_W-1:0]  feat_cnt_q;
	logic [CLOCK_CNT_W-1:0] clk_cnt_q;

	logic        hdr_hit;
	logic        in_hit;
	logic        out_hit;
	logic        feat_hit;
	logic        clk_hit;
	logic [15:0] bcd;
	logic [7:0]  ctl;
	logic [7:0]  len;
	desc_bytes_t b;

	assign b   = walk.bytes;
	assign len = walk.len;
	assign bcd = {b[4], b[3]};

	// Decode a completed class-specific descriptor
	always_comb begin
		rec      = '0;
		hdr_hit  = 1'b0;
		in_hit   = 1'b0;
		out_hit  = 1'b0;
		feat_hit = 1'b0;
		clk_hit  = 1'b0;
		ctl      = 8'd0;
		if (walk.done && (b[1] == CS_IFACE)) begin
			case (b[2])
				ST_HEADER: begin
					hdr_hit = (len >= 8'd8);
					rec.record_kind = KIND_HEADER;
					rec.type_word   = bcd;
				end
				ST_INPUT: begin
					in_hit = (in_cnt_q < TERM_CNT_W'(MAX_TERMINALS)) && (len >= 8'd12);
					rec.record_kind    = KIND_INPUT;
					rec.table_slot     = 3'(in_cnt_q);
					rec.entity_id      = b[3];
					rec.type_word      = {b[5], b[4]};
					rec.assoc_terminal = b[6];
					rec.channel_count  = b[7];
					rec.channel_config = {b[9], b[8]};
					if ((version_q == VER_2) && (len >= 8'd17)) begin
						rec.clock_source_id = b[12];
					end
				end
				ST_OUTPUT: begin
					out_hit = (out_cnt_q < TERM_CNT_W'(MAX_TERMINALS)) && (len >= 8'd9);
					rec.record_kind    = KIND_OUTPUT;
					rec.table_slot     = 3'(out_cnt_q);
					rec.entity_id      = b[3];
					rec.type_word      = {b[5], b[4]};
					rec.assoc_terminal = b[6];
					rec.source_id      = b[7];
					if ((version_q == VER_2) && (len >= 8'd12)) begin
						rec.clock_source_id = b[8];
					end
				end
				ST_FEATURE: begin
					feat_hit = (feat_cnt_q < FEAT_CNT_W'(MAX_FEATURE_UNITS)) && (len >= 8'd7);
					rec.record_kind = KIND_FEATURE;
					rec.table_slot  = 3'(feat_cnt_q);
					rec.entity_id   = b[3];
					rec.source_id   = b[4];
					if (version_q == VER_1) begin
						if ((b[5] != 8'd0) && ({1'b0, len} >= (9'd7 + {1'b0, b[5]}))) begin
							ctl = b[6];
						end
						rec.feature_flags = ctl[1:0];
					end else begin
						if (len >= 8'd10) begin
							ctl = b[6];
						end
						rec.feature_flags = {|(ctl & VOLUME_MASK), |(ctl & MUTE_MASK)};
					end
					rec.control_bits = ctl & BYTE_MASK;
				end
				ST_CLOCK: begin
					clk_hit = (version_q == VER_2)
						&& (clk_cnt_q < CLOCK_CNT_W'(MAX_CLOCK_SOURCES)) && (len >= 8'd8);
					rec.record_kind      = KIND_CLOCK;
					rec.table_slot       = 3'(clk_cnt_q);
					rec.entity_id        = b[3];
					rec.clock_attributes = b[4];
					rec.control_bits     = b[5];
					rec.assoc_terminal   = b[6];
				end
				default: ;
			endcase
		end
	end

	assign rec_valid = hdr_hit || in_hit || out_hit || feat_hit || clk_hit;

	// Version and table counts: cleared only by reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			version_q  <= VER_UNKNOWN;
			in_cnt_q   <= '0;
			out_cnt_q  <= '0;
			feat_cnt_q <= '0;
			clk_cnt_q  <= '0;
		end else begin
			if (hdr_hit) begin
				version_q <= (bcd >= BCD_UAC2) ? VER_2 : VER_1;
			end
			if (in_hit) begin
				in_cnt_q <= in_cnt_q + TERM_CNT_W'(1);
			end
			if (out_hit) begin
				out_cnt_q <= out_cnt_q + TERM_CNT_W'(1);
			end
			if (feat_hit) begin
				feat_cnt_q <= feat_cnt_q + FEAT_CNT_W'(1);
			end
			if (clk_hit) begin
				clk_cnt_q <= clk_cnt_q + CLOCK_CNT_W'(1);
			end
		end
	end

endmodule

### hdl/uac_control_descriptor_parser_core.sv
// The input register holds a descriptor's final byte, and the record register then holds its record.
// Throughput: one byte per cycle; the input register and the record register each hold
// one transfer, and the input side stalls only while a record waits to be taken.
// Reset (arst_n low) clears the walk, the class version and all table counts; the
// captured descriptor bytes are not reset.
`include "assert_macros.svh"

module uac_control_descriptor_parser_core import uac_cdp_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_ready,
	input  item_t   item,
	output logic    record_valid,
	input  logic    record_ready,
	output record_t record
);

	logic    valid_s1;
	item_t   item_s1;
	logic    advance;
	walk_t   walk;
	logic    rec_valid;
	record_t rec;
	logic    out_valid_q;
	record_t out_q;

	// Process the held byte when the record register is free or being emptied
	assign advance    = valid_s1 && (!out_valid_q || record_ready);
	assign item_ready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item;
		end
	end

	uac_cdp_walker u_walker (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.walk   (walk)
	);

	uac_cdp_decoder u_decoder (
		.clk       (clk),
		.arst_n    (arst_n),
		.walk      (walk),
		.rec_valid (rec_valid),
		.rec       (rec)
	);

	// Record register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= rec_valid;
		end else if (record_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && rec_valid) begin
			out_q <= rec;
		end
	end

	assign record_valid = out_valid_q;
	assign record       = out_q;

	`ASSERT_IMP(a_no_overwrite, out_valid_q && !record_ready, !advance, "record overwritten while stalled")
	`ASSERT_IMP(a_empty_takes, !valid_s1, item_ready, "input register empty but not ready")
	`ASSERT_IMP(a_kind_range, record_valid, record.record_kind <= KIND_CLOCK, "record kind out of range")
	`ASSERT_IMP(a_header_zero, record_valid && (record.record_kind == KIND_HEADER), (record.table_slot == 3'd0) && (record.entity_id == 8'd0), "header record carries slot or id")

endmodule
